// ===== rtl/length_prefixed_record_ring_unit_assert.svh =====
`ifndef LENGTH_PREFIXED_RECORD_RING_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_RING_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LPR_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("lpr check failed");
// Next-cycle implication.
`define LPR_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("lpr check failed");
`endif

// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;
	localparam int BufBytes = 1024;
	localparam int AddrW = $clog2(BufBytes);
	localparam int IdxW = AddrW + 1;
	localparam int MaxRec = BufBytes / 2;
	localparam int HdrBytes = 4;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP = 2'd1;
	localparam logic [1:0] FUNC_STAT = 2'd2;
	localparam logic [1:0] FUNC_CLR = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOSPACE = 3'd1;
	localparam logic [2:0] ST_BADLEN = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_BADHDR = 3'd4;
	localparam logic [2:0] ST_DROP = 3'd5;

	typedef struct packed {
		logic [1:0] func;
		logic first_beat;
		logic [15:0] record_len;
		logic [63:0] data_word;
		logic [15:0] pop_limit;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [63:0] out_word;
		logic [3:0] beat_bytes;
		logic last_beat;
		logic [9:0] record_bytes;
		logic [10:0] used_bytes;
		logic overrun_bit;
		logic [63:0] written_count;
		logic [63:0] read_count;
		logic [63:0] overrun_total;
	} out_item_t;
endpackage

// ===== rtl/lpr_mem.sv =====
// Byte-lane memory: eight byte banks, so any eight consecutive bytes are one access.
module lpr_mem (
	input logic clk,
	input logic [7:0] we,
	input logic [7:0][lpr_pkg::AddrW-1:0] waddr,
	input logic [7:0][7:0] wdata,
	input logic [7:0][lpr_pkg::AddrW-1:0] raddr,
	output logic [7:0][7:0] rdata
);
	for (genvar b = 0; b < 8; b++) begin : g_bank
		logic [7:0] mem [lpr_pkg::BufBytes/8];
		logic [7:0] rd_q;
		always_ff @(posedge clk) begin
			if (we[b]) begin
				mem[waddr[b][lpr_pkg::AddrW-1:3]] <= wdata[b];
			end
			rd_q <= mem[raddr[b][lpr_pkg::AddrW-1:3]];
		end
		assign rdata[b] = rd_q;
	end
endmodule

// ===== rtl/length_prefixed_record_ring_unit.sv =====
// Record ring of 1024 bytes in an eight-bank byte memory. An item is taken at an edge where
// start is high and busy is low, and each result is shown for exactly one cycle with done
// high; results cannot be held off, so the receiver must take every beat as it comes. A push,
// status or clear beat has its one result registered at the edge that takes it and normally
// leaves busy low, so the next beat may follow at once. A first push beat of a record longer
// than four bytes keeps busy high while the rest of the beat is stored, because the header
// fills four of the eight banks and payload bytes four to seven are written afterwards. A pop
// gets its header back in S_HDR and then computes one payload beat per cycle in S_DATA, up to
// 64 beats; its first beat passes through S_HDR, S_DATA and the output register, and busy drops
// in the cycle that shows its last beat. An empty pop answers at the edge that takes it, a bad
// header from S_HDR.
module length_prefixed_record_ring_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lpr_pkg::in_item_t in_item,
	output logic done,
	output lpr_pkg::out_item_t out_item
);
	localparam int AW = lpr_pkg::AddrW;
	localparam int IW = lpr_pkg::IdxW;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HDR = 2'd1;
	localparam logic [1:0] S_DATA = 2'd2;

	logic [1:0] state_q;
	logic [IW-1:0] wr_q, rd_q, stg_q, pos_q;
	logic [9:0] rem_q, left_q, hdr_q;
	logic drop_q, ovr_q;
	logic [63:0] wtot_q, rtot_q, otot_q;
	logic [15:0] lim_q;
	logic spill_s1;
	logic [IW-1:0] spill_pos_s1;
	logic [3:0] spill_n_s1;
	logic [31:0] spill_d_s1;

	logic [1:0] state_nx;
	logic [IW-1:0] wr_nx, rd_nx, stg_nx, pos_nx;
	logic [9:0] rem_nx, left_nx, hdr_nx;
	logic drop_nx, ovr_nx;
	logic [63:0] wtot_nx, rtot_nx, otot_nx;
	logic [15:0] lim_nx;
	logic spill_nx;
	logic [IW-1:0] spill_pos_nx;
	logic [3:0] spill_cnt_nx;
	logic [31:0] spill_dat_nx;
	logic done_nx;
	lpr_pkg::out_item_t out_nx;

	logic [7:0] we;
	logic [7:0][AW-1:0] waddr, raddr;
	logic [7:0][7:0] wdata, rdata;

	lpr_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	wire acc = start && !busy;
	wire [IW-1:0] used = wr_q - rd_q;

	// Read ring position p+k for each bank: bank b holds byte b of each lane.
	function automatic logic [7:0][AW-1:0] lane_addr(input logic [IW-1:0] p);
		logic [7:0][AW-1:0] a;
		logic [AW-1:0] k;
		for (int b = 0; b < 8; b++) begin
			k = AW'((b - int'(p[2:0])) & 7);
			a[b] = p[AW-1:0] + k;
		end
		return a;
	endfunction

	function automatic logic [63:0] gather(input logic [7:0][7:0] d,
			input logic [2:0] s);
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			w[8*i +: 8] = d[3'(i) + s];
		end
		return w;
	endfunction

	// Push write path.
	logic len_ok, push_hdr_ok, push_stage;
	logic [IW-1:0] wbase;
	logic [3:0] nput;
	logic [10:0] need;
	always_comb begin
		need = 11'(used) + 11'(lpr_pkg::HdrBytes) + 11'(in_item.record_len[9:0]);
		len_ok = in_item.record_len != 16'd0
			&& in_item.record_len <= 16'(lpr_pkg::MaxRec);
		push_hdr_ok = in_item.first_beat && len_ok && need <= 11'(lpr_pkg::BufBytes);
		push_stage = acc && in_item.func == lpr_pkg::FUNC_PUSH
			&& (push_hdr_ok || (!in_item.first_beat && !drop_q && rem_q != 10'd0));
		wbase = push_hdr_ok ? wr_q : stg_q;
		if (push_hdr_ok) begin
			nput = (in_item.record_len < 16'd8) ? 4'(in_item.record_len) + 4'd4 : 4'd12;
		end else begin
			nput = (rem_q < 10'd8) ? 4'(rem_q) : 4'd8;
		end
		// A first beat writes the header and the first four payload bytes; the rest
		// of that beat goes out in the following cycle.
		for (int b = 0; b < 8; b++) begin
			logic [2:0] k;
			logic [2:0] ks;
			k = 3'(b) - wbase[2:0];
			ks = 3'(b) - spill_pos_s1[2:0];
			waddr[b] = wbase[AW-1:0] + AW'(k);
			if (push_hdr_ok) begin
				wdata[b] = (k < 3'd4) ? 8'({16'd0, in_item.record_len} >> (8*k))
					: in_item.data_word[8*k[1:0] +: 8];
			end else begin
				wdata[b] = in_item.data_word[8*k +: 8];
			end
			we[b] = push_stage && (4'(k) < nput);
			if (spill_s1) begin
				we[b] = 4'(ks) < spill_n_s1;
				waddr[b] = spill_pos_s1[AW-1:0] + AW'(ks);
				wdata[b] = spill_d_s1[8*ks[1:0] +: 8];
			end
		end
	end

	assign busy = state_q != S_IDLE || spill_s1;

	logic [63:0] hdr_word;
	logic [31:0] hdr_w;
	logic [63:0] dat_w;
	logic [3:0] nget;
	assign hdr_word = gather(rdata, rd_q[2:0]);
	assign hdr_w = hdr_word[31:0];
	assign dat_w = gather(rdata, pos_q[2:0]);
	assign nget = (left_q < 10'd8) ? 4'(left_q) : 4'd8;

	// The read issued in one cycle is the data seen in the next one.
	logic [IW-1:0] rpos;
	always_comb begin
		unique case (state_q)
			S_HDR: rpos = rd_q + IW'(lpr_pkg::HdrBytes);
			S_DATA: rpos = pos_q + IW'(nget);
			default: rpos = rd_q;
		endcase
		raddr = lane_addr(rpos);
	end

	logic fin;
	logic [2:0] st;
	logic [9:0] take;
	logic [63:0] mask;
	always_comb begin
		state_nx = state_q;
		wr_nx = wr_q; rd_nx = rd_q; stg_nx = stg_q; pos_nx = pos_q;
		rem_nx = rem_q; left_nx = left_q; hdr_nx = hdr_q;
		drop_nx = drop_q; ovr_nx = ovr_q;
		wtot_nx = wtot_q; rtot_nx = rtot_q; otot_nx = otot_q;
		lim_nx = lim_q;
		spill_nx = 1'b0;
		spill_pos_nx = spill_pos_s1;
		spill_cnt_nx = spill_n_s1;
		spill_dat_nx = spill_d_s1;
		done_nx = 1'b0;
		out_nx = '0;
		st = lpr_pkg::ST_OK;
		fin = 1'b0;
		take = (in_item.record_len < 16'd8) ? in_item.record_len[9:0] : 10'd8;
		mask = (nget == 4'd8) ? '1 : ((64'd1 << (8*nget)) - 64'd1);
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					fin = 1'b1;
					unique case (in_item.func)
						lpr_pkg::FUNC_PUSH: begin
							if (in_item.first_beat) begin
								rem_nx = '0;
								drop_nx = 1'b0;
								if (!len_ok) begin
									drop_nx = 1'b1;
									st = lpr_pkg::ST_BADLEN;
								end else if (!push_hdr_ok) begin
									drop_nx = 1'b1;
									ovr_nx = 1'b1;
									otot_nx = otot_q + 64'd1;
									st = lpr_pkg::ST_NOSPACE;
								end else begin
									spill_nx = in_item.record_len[9:0] > 10'd4;
									spill_pos_nx = wr_q + IW'(8);
									spill_cnt_nx = (in_item.record_len < 16'd8)
										? 4'(in_item.record_len) - 4'd4 : 4'd4;
									spill_dat_nx = in_item.data_word[63:32];
									stg_nx = wr_q + IW'(lpr_pkg::HdrBytes) + IW'(take);
									rem_nx = in_item.record_len[9:0] - take;
									if (rem_nx == 10'd0) begin
										wr_nx = stg_nx;
										wtot_nx = wtot_q + 64'd1;
									end
								end
							end else if (drop_q || rem_q == 10'd0) begin
								st = lpr_pkg::ST_DROP;
							end else begin
								stg_nx = stg_q + IW'(nput);
								rem_nx = rem_q - 10'(nput);
								if (rem_nx == 10'd0) begin
									wr_nx = stg_nx;
									wtot_nx = wtot_q + 64'd1;
								end
							end
						end
						lpr_pkg::FUNC_POP: begin
							if (used == '0) begin
								st = lpr_pkg::ST_EMPTY;
							end else begin
								fin = 1'b0;
								lim_nx = in_item.pop_limit;
								state_nx = S_HDR;
							end
						end
						lpr_pkg::FUNC_STAT: ;
						lpr_pkg::FUNC_CLR: ovr_nx = 1'b0;
						default: ;
					endcase
				end
			end
			S_HDR: begin
				if (hdr_w == 32'd0 || hdr_w > {16'd0, lim_q}
					|| hdr_w > 32'(lpr_pkg::MaxRec)) begin
					fin = 1'b1;
					st = lpr_pkg::ST_BADHDR;
					state_nx = S_IDLE;
				end else begin
					hdr_nx = hdr_w[9:0];
					left_nx = hdr_w[9:0];
					pos_nx = rd_q + IW'(lpr_pkg::HdrBytes);
					state_nx = S_DATA;
				end
			end
			S_DATA: begin
				done_nx = 1'b1;
				out_nx.status = lpr_pkg::ST_OK;
				out_nx.out_word = dat_w & mask;
				out_nx.beat_bytes = nget;
				out_nx.record_bytes = hdr_q;
				out_nx.last_beat = left_q <= 10'd8;
				out_nx.used_bytes = 11'(wr_q - rd_q - IW'(lpr_pkg::HdrBytes) - IW'(hdr_q));
				out_nx.overrun_bit = ovr_q;
				out_nx.written_count = wtot_q;
				out_nx.read_count = rtot_q + 64'd1;
				out_nx.overrun_total = otot_q;
				left_nx = left_q - 10'(nget);
				pos_nx = pos_q + IW'(nget);
				if (left_q <= 10'd8) begin
					rd_nx = rd_q + IW'(lpr_pkg::HdrBytes) + IW'(hdr_q);
					rtot_nx = rtot_q + 64'd1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		if (fin) begin
			done_nx = 1'b1;
			out_nx.status = st;
			out_nx.last_beat = 1'b1;
			out_nx.overrun_bit = (state_q == S_IDLE
				&& in_item.func == lpr_pkg::FUNC_CLR) ? ovr_q : ovr_nx;
			out_nx.used_bytes = 11'(wr_nx - rd_nx);
			out_nx.written_count = wtot_nx;
			out_nx.read_count = rtot_nx;
			out_nx.overrun_total = otot_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q <= '0; rd_q <= '0; stg_q <= '0; pos_q <= '0;
			rem_q <= '0; left_q <= '0; hdr_q <= '0;
			drop_q <= 1'b0; ovr_q <= 1'b0;
			wtot_q <= '0; rtot_q <= '0; otot_q <= '0;
			lim_q <= '0; done <= 1'b0; out_item <= '0;
			spill_s1 <= 1'b0; spill_pos_s1 <= '0; spill_n_s1 <= '0; spill_d_s1 <= '0;
		end else begin
			state_q <= state_nx;
			wr_q <= wr_nx; rd_q <= rd_nx; stg_q <= stg_nx; pos_q <= pos_nx;
			rem_q <= rem_nx; left_q <= left_nx; hdr_q <= hdr_nx;
			drop_q <= drop_nx; ovr_q <= ovr_nx;
			wtot_q <= wtot_nx; rtot_q <= rtot_nx; otot_q <= otot_nx;
			lim_q <= lim_nx; done <= done_nx; out_item <= out_nx;
			spill_s1 <= spill_nx; spill_pos_s1 <= spill_pos_nx;
			spill_n_s1 <= spill_cnt_nx; spill_d_s1 <= spill_dat_nx;
		end
	end

	`include "length_prefixed_record_ring_unit_assert.svh"
	`LPR_ASSERT_IMP(a_used_bound, 1'b1, used <= IW'(lpr_pkg::BufBytes))
	`LPR_ASSERT_NXT(a_acc_busy, acc && in_item.func == lpr_pkg::FUNC_POP && used != '0, busy)
	`LPR_ASSERT_IMP(a_stage_ahead, 1'b1, IW'(stg_q - rd_q) <= IW'(lpr_pkg::BufBytes))
endmodule
